### sv/etc_pkg.sv
// ----------------------------------------------------------------------------
// etc_pkg
// Shared types and constants for the edge trigger capture block.
// ----------------------------------------------------------------------------
`default_nettype none

package etc_pkg;

  localparam int RING_DEPTH_DEF    = 2048;
  localparam int SEARCH_SPAN_DEF   = 1024;
  localparam int PRE_TRIGGER_DEF   = 64;
  localparam int WINDOW_LENGTH_DEF = 128;
  localparam int SAMPLE_BITS_DEF   = 10;

  // port field widths
  localparam int LEVEL_W  = 10;
  localparam int SAMPLE_W = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(563);

  typedef enum logic {
    OP_STORE   = 1'b0,
    OP_CAPTURE = 1'b1
  } op_t;

  typedef enum logic {
    CFG_TRIGGER_LEVEL = 1'b0,
    CFG_RISING_EDGE   = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               rising;
  } trig_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SEARCH,
    ST_WIN_A,
    ST_WIN_B,
    ST_WIN_C,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

### sv/etc_ring.sv
// ----------------------------------------------------------------------------
// etc_ring
// Sample ring memory: one write port, one registered read port. Entries not
// yet written since reset read as zero, tracked by a fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_ring #(
  parameter int RING_DEPTH  = etc_pkg::RING_DEPTH_DEF,
  parameter int SAMPLE_BITS = etc_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W       = $clog2(RING_DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   wr_en,
  input  wire logic [IDX_W-1:0]       wr_addr,
  input  wire logic [SAMPLE_BITS-1:0] wr_data,
  input  wire logic [IDX_W-1:0]       rd_addr,
  output logic      [SAMPLE_BITS-1:0] rd_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] mem_q;
  logic                   ok_r;
  logic [IDX_W-1:0]       fill_r;
  logic                   full_r;

  // writes land in order from index 0, so fill_r marks the written prefix
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      full_r <= 1'b0;
    end else if (wr_en && !full_r) begin
      if (fill_r == LAST_IDX) begin
        full_r <= 1'b1;
      end else begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r <= 1'b0;
    end else begin
      ok_r <= full_r || (rd_addr < fill_r);
    end
  end

  assign rd_data = ok_r ? mem_q : '0;

endmodule

`default_nettype wire

### sv/etc_edge.sv
// ----------------------------------------------------------------------------
// etc_edge
// Trigger compare unit: tests one adjacent sample pair for a crossing.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_edge #(
  parameter int SAMPLE_BITS = etc_pkg::SAMPLE_BITS_DEF
) (
  input  wire etc_pkg::trig_cfg_t       cfg,
  input  wire logic [SAMPLE_BITS-1:0]   prev,
  input  wire logic [SAMPLE_BITS-1:0]   cur,
  output logic                          hit
);

  localparam int CMP_W = (SAMPLE_BITS > etc_pkg::LEVEL_W) ? SAMPLE_BITS : etc_pkg::LEVEL_W;

  logic [CMP_W-1:0] prev_e;
  logic [CMP_W-1:0] cur_e;
  logic [CMP_W-1:0] lvl_e;

  assign prev_e = CMP_W'(prev);
  assign cur_e  = CMP_W'(cur);
  assign lvl_e  = CMP_W'(cfg.level);

  assign hit = cfg.rising ? ((prev_e <= lvl_e) && (cur_e >= lvl_e))
                          : ((prev_e >= lvl_e) && (cur_e <= lvl_e));

endmodule

`default_nettype wire

### sv/etc_ctrl.sv
// ----------------------------------------------------------------------------
// etc_ctrl
// Sequencer: stores samples, walks the ring backward one step per cycle
// through the compare unit, then reads the window out pair by pair.
// ----------------------------------------------------------------------------
`default_nettype none

module etc_ctrl #(
  parameter int RING_DEPTH    = etc_pkg::RING_DEPTH_DEF,
  parameter int SEARCH_SPAN   = etc_pkg::SEARCH_SPAN_DEF,
  parameter int PRE_TRIGGER   = etc_pkg::PRE_TRIGGER_DEF,
  parameter int WINDOW_LENGTH = etc_pkg::WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = etc_pkg::SAMPLE_BITS_DEF,
  parameter int IDX_W         = $clog2(RING_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire etc_pkg::trig_cfg_t            cfg,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic                          in_opcode,
  input  wire logic [etc_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic      [etc_pkg::SAMPLE_W-1:0]  out_first,
  output logic      [etc_pkg::SAMPLE_W-1:0]  out_second,
  output logic                               out_found,
  output logic                               out_last,
  output logic                               wr_en,
  output logic      [IDX_W-1:0]              wr_addr,
  output logic      [SAMPLE_BITS-1:0]        wr_data,
  output logic      [IDX_W-1:0]              rd_addr,
  input  wire logic [SAMPLE_BITS-1:0]        rd_data
);

  localparam int CMP_W  = (SAMPLE_BITS > etc_pkg::SAMPLE_W) ? SAMPLE_BITS : etc_pkg::SAMPLE_W;
  localparam int PAIRS  = (WINDOW_LENGTH + 1) / 2;
  localparam int PAIR_W = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int CNT_W  = $clog2(SEARCH_SPAN);

  localparam logic [IDX_W:0]    DEPTH_C    = (IDX_W+1)'(RING_DEPTH);
  localparam logic [IDX_W:0]    PRE_C      = (IDX_W+1)'(PRE_TRIGGER);
  localparam logic [IDX_W:0]    HALF_C     = (IDX_W+1)'(WINDOW_LENGTH / 2);
  localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(SEARCH_SPAN - 1);
  localparam logic [PAIR_W-1:0] PAIR_LAST  = PAIR_W'(PAIRS - 1);

  function automatic logic [IDX_W-1:0] ring_sub(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W:0]   k);
    logic [IDX_W:0] ae;
    logic [IDX_W:0] s;
    ae = {1'b0, a};
    if (ae >= k) begin
      s = ae - k;
    end else begin
      s = ae + DEPTH_C - k;
    end
    return s[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] a);
    return (a == LAST_IDX) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? LAST_IDX : a - 1'b1;
  endfunction

  etc_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]           newest_r, newest_nxt;
  logic [IDX_W-1:0]           trig_r, trig_nxt;
  logic [IDX_W-1:0]           cand_r, cand_nxt;
  logic [IDX_W-1:0]           wp_r, wp_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [PAIR_W-1:0]          k_r, k_nxt;
  logic [SAMPLE_BITS-1:0]     cur_r, cur_nxt;
  logic                       found_r, found_nxt;
  logic [etc_pkg::SAMPLE_W-1:0] first_r, first_nxt;
  logic [etc_pkg::SAMPLE_W-1:0] second_r, second_nxt;

  logic                       hit;
  logic [CMP_W-1:0]           in_ext;
  logic [CMP_W-1:0]           rd_ext;

  assign in_ext = CMP_W'(in_sample);
  assign rd_ext = CMP_W'(rd_data);

  etc_edge #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_edge (
    .cfg  (cfg),
    .prev (rd_data),
    .cur  (cur_r),
    .hit  (hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= etc_pkg::ST_IDLE;
      newest_r <= LAST_IDX;
      trig_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      newest_r <= newest_nxt;
      trig_r   <= trig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r   <= cand_nxt;
    wp_r     <= wp_nxt;
    cnt_r    <= cnt_nxt;
    k_r      <= k_nxt;
    cur_r    <= cur_nxt;
    found_r  <= found_nxt;
    first_r  <= first_nxt;
    second_r <= second_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    newest_nxt = newest_r;
    trig_nxt   = trig_r;
    cand_nxt   = cand_r;
    wp_nxt     = wp_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    cur_nxt    = cur_r;
    found_nxt  = found_r;
    first_nxt  = first_r;
    second_nxt = second_r;

    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = ring_inc(newest_r);
    wr_data    = in_ext[SAMPLE_BITS-1:0];
    rd_addr    = wp_r;

    unique case (state_r)
      etc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        rd_addr   = ring_sub(newest_r, PRE_C);
        if (in_tvalid) begin
          if (in_opcode == etc_pkg::OP_STORE) begin
            wr_en      = 1'b1;
            newest_nxt = ring_inc(newest_r);
          end else begin
            cand_nxt  = ring_sub(newest_r, PRE_C);
            found_nxt = 1'b0;
            state_nxt = etc_pkg::ST_FIRST;
          end
        end
      end
      etc_pkg::ST_FIRST: begin
        rd_addr   = ring_dec(cand_r);
        cur_nxt   = rd_data;
        cnt_nxt   = '0;
        state_nxt = etc_pkg::ST_SEARCH;
      end
      etc_pkg::ST_SEARCH: begin
        // rd_data holds the entry just before the candidate
        rd_addr = ring_dec(ring_dec(cand_r));
        k_nxt   = '0;
        if (hit) begin
          found_nxt = 1'b1;
          trig_nxt  = cand_r;
          wp_nxt    = ring_sub(cand_r, HALF_C);
          state_nxt = etc_pkg::ST_WIN_A;
        end else if (cnt_r == CNT_LAST) begin
          wp_nxt    = ring_sub(trig_r, HALF_C);
          state_nxt = etc_pkg::ST_WIN_A;
        end else begin
          cand_nxt = ring_dec(cand_r);
          cur_nxt  = rd_data;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      etc_pkg::ST_WIN_A: begin
        rd_addr   = wp_r;
        state_nxt = etc_pkg::ST_WIN_B;
      end
      etc_pkg::ST_WIN_B: begin
        rd_addr   = ring_inc(wp_r);
        wp_nxt    = ring_inc(wp_r);
        first_nxt = rd_ext[etc_pkg::SAMPLE_W-1:0];
        state_nxt = etc_pkg::ST_WIN_C;
      end
      etc_pkg::ST_WIN_C: begin
        second_nxt = rd_ext[etc_pkg::SAMPLE_W-1:0];
        state_nxt  = etc_pkg::ST_OUT;
      end
      etc_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (k_r == PAIR_LAST) begin
            state_nxt = etc_pkg::ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            wp_nxt    = ring_inc(wp_r);
            state_nxt = etc_pkg::ST_WIN_A;
          end
        end
      end
      default: begin
        state_nxt = etc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_first  = first_r;
  assign out_second = second_r;
  assign out_found  = found_r;
  assign out_last   = (k_r == PAIR_LAST);

endmodule

`default_nettype wire

### sv/edge_trigger_capture.sv
// ----------------------------------------------------------------------------
// edge_trigger_capture
// Sample ring with backward edge search and windowed readout.
// ----------------------------------------------------------------------------
// A store beat (tuser 0) writes one sample and leaves in_tready high for the
// next beat. A capture beat (tuser 1) holds in_tready low while it works: a
// prime state (ST_FIRST), then up to SEARCH_SPAN search steps, since the search
// reads the ring once per step through its single read port into one shared
// compare unit. Readout then steps through WIN_A, WIN_B, WIN_C and OUT for each
// output pair, waiting in OUT while out_tready is low, for ceil(WINDOW_LENGTH/2)
// beats, the last one flagged on out_tlast. Ring entries not yet written after
// reset read as zero through a fill count, so reset needs no clearing pass.
// Configuration writes are taken any cycle.
`default_nettype none

module edge_trigger_capture #(
  parameter int RING_DEPTH    = etc_pkg::RING_DEPTH_DEF,
  parameter int SEARCH_SPAN   = etc_pkg::SEARCH_SPAN_DEF,
  parameter int PRE_TRIGGER   = etc_pkg::PRE_TRIGGER_DEF,
  parameter int WINDOW_LENGTH = etc_pkg::WINDOW_LENGTH_DEF,
  parameter int SAMPLE_BITS   = etc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [9:0] sample_value
  input  wire logic        in_tuser,   // [0] opcode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,  // [9:0] first_sample, [19:10] second_sample
  output logic             out_tuser,  // [0] trigger_found
  output logic             out_tlast,  // last_pair
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [9:0]  cfg_data
);

  localparam int IDX_W = $clog2(RING_DEPTH);

  etc_pkg::trig_cfg_t cfg_r;

  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [SAMPLE_BITS-1:0]       wr_data;
  logic [IDX_W-1:0]             rd_addr;
  logic [SAMPLE_BITS-1:0]       rd_data;
  logic [etc_pkg::SAMPLE_W-1:0] first;
  logic [etc_pkg::SAMPLE_W-1:0] second;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level  <= etc_pkg::LEVEL_RESET;
      cfg_r.rising <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        etc_pkg::CFG_TRIGGER_LEVEL: cfg_r.level  <= cfg_data;
        etc_pkg::CFG_RISING_EDGE:   cfg_r.rising <= cfg_data[0];
        default: ;
      endcase
    end
  end

  etc_ring #(
    .RING_DEPTH  (RING_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .IDX_W       (IDX_W)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  etc_ctrl #(
    .RING_DEPTH    (RING_DEPTH),
    .SEARCH_SPAN   (SEARCH_SPAN),
    .PRE_TRIGGER   (PRE_TRIGGER),
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .IDX_W         (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_opcode  (in_tuser),
    .in_sample  (in_tdata[9:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_first  (first),
    .out_second (second),
    .out_found  (out_tuser),
    .out_last   (out_tlast),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  assign out_tdata = {4'b0000, second, first};

endmodule

`default_nettype wire
